// File: design/scca_pkg.sv
// ============================================================================
// Size-class chunk allocator package
// Shared constants, codes and types for the size-class chunk allocator.
// ============================================================================
package scca_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int POOL_PAGES   = 64;
    localparam int HEADER_BYTES = 8;

    localparam int NUM_CLASSES    = 7;
    localparam int SLOT_BYTES     = 32;
    localparam int SLOT_SHIFT     = 5;
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / SLOT_BYTES;
    localparam int CHUNK_SLOTS    = POOL_PAGES * SLOTS_PER_PAGE;

    localparam int ADDR_W  = 18;
    localparam int REQ_W   = 21;
    localparam int CLS_W   = 3;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 14;
    localparam int SLOT_W  = $clog2(CHUNK_SLOTS);
    localparam int PAGE_W  = $clog2(POOL_PAGES);
    localparam int NUP_W   = $clog2(POOL_PAGES + 1);
    localparam int IDX_W   = $clog2(SLOTS_PER_PAGE);
    localparam int NCH_W   = $clog2(SLOTS_PER_PAGE + 1);
    localparam int PGOFF_W = $clog2(PAGE_BYTES);

    localparam logic [CNT_W-1:0] AVAIL_MAX = {CNT_W{1'b1}};

    localparam logic [CLS_W-1:0] NO_CLASS = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_PAGES  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_FREE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd4;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [STAT_W-1:0] status;
    } scca_dec_t;

endpackage

// File: design/scca_size_decode.sv
// ============================================================================
// Size-class decoder
// Adds the header to a requested size and picks the smallest class that fits.
// ============================================================================
module scca_size_decode
    import scca_pkg::*;
(
    input  logic [REQ_W-1:0] request_bytes,
    output scca_dec_t        dec
);

    logic [REQ_W:0]      need;
    logic [NUM_CLASSES-1:0] fits;

    assign need = {1'b0, request_bytes} + (REQ_W+1)'(HEADER_BYTES);

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            fits[k] = need <= (REQ_W+1)'(SLOT_BYTES << k);
        end
    end

    always_comb
    begin
        dec.cls    = NO_CLASS;
        dec.status = ST_TOO_LARGE;
        for (int k = NUM_CLASSES - 1; k >= 0; k--)
        begin
            if (fits[k])
            begin
                dec.cls    = CLS_W'(k);
                dec.status = ST_OK;
            end
        end
        if (request_bytes == '0)
        begin
            dec.cls    = NO_CLASS;
            dec.status = ST_ZERO_SIZE;
        end
    end

endmodule

// File: design/size_class_chunk_allocator.sv
// ============================================================================
// Size-class chunk allocator
// Segregated-fit allocator with seven size classes over a pool of pages.
// ============================================================================
// Requests enter on the s_axis channel: tuser selects allocate or free, and
// tdata carries the size and the address. Each request gives exactly one
// response on the m_axis channel with the granted address, the class, a
// status code and the free count left in that class.
// An allocate from a class with free chunks, any free and any error go
// to a work state (S_POP, S_FREE, S_RESP) that loads the output register.
// An allocate that finds its class empty first links a fresh page, one
// chunk per cycle (4096 / class size chunks, 2 to 128), then reads and pops the new head.
// The chunk links live in a single-port synchronous memory, so one request
// is in work at a time.
// After reset the block links pages 0 to 6 for classes 0 to 6 and holds
// s_axis_tready low meanwhile.
// The response sits in an output register; a new request is accepted while
// it waits, and work stalls only when a second response is ready to load.
// ============================================================================
module size_class_chunk_allocator
    import scca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // request_bytes[20:0], freed_address[38:21]
    input  logic        s_axis_tuser,  // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // granted_address[17:0], size_class[20:18],
                                       // status[23:21], class_free_chunks[37:24]
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LINK   = 3'd1;
    localparam logic [2:0] S_POP_RD = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              init_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [NUP_W-1:0]  next_page_reg;
    logic [PAGE_W-1:0] link_page_reg;
    logic [IDX_W-1:0]  link_idx_reg;
    logic [SLOT_W-1:0] head_reg  [NUM_CLASSES];
    logic [CNT_W-1:0]  avail_reg [NUM_CLASSES];

    logic [SLOT_W-1:0] chunk_next [CHUNK_SLOTS];
    logic [CLS_W-1:0]  page_tag   [POOL_PAGES];
    logic [SLOT_W-1:0] next_rdata_reg;
    logic [CLS_W-1:0]  tag_rdata_reg;

    logic              m_valid_reg;
    logic [39:0]       m_data_reg;

    scca_dec_t         dec;
    logic              accept;
    logic              out_free;
    logic              load_out;
    logic [39:0]       load_data;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;

    logic [NCH_W-1:0]  link_n;
    logic              link_last;
    logic [IDX_W-1:0]  link_off;
    logic [IDX_W-1:0]  link_off_nx;
    logic [CNT_W:0]    link_sum;

    logic [ADDR_W-1:0] base;
    logic [PAGE_W-1:0] free_page;
    logic [SLOT_W-1:0] free_slot;
    logic              free_bad;
    logic [IDX_W-1:0]  free_mask;
    logic [CNT_W-1:0]  cur_avail;
    logic [CNT_W-1:0]  inc_avail;

    scca_size_decode u_dec (
        .request_bytes (s_axis_tdata[20:0]),
        .dec           (dec)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign cur_avail = avail_reg[cls_reg];
    assign inc_avail = (cur_avail == AVAIL_MAX) ? AVAIL_MAX : cur_avail + 1'b1;

    assign link_n      = NCH_W'(SLOTS_PER_PAGE) >> cls_reg;
    assign link_last   = ({1'b0, link_idx_reg} == link_n - 1'b1);
    assign link_off    = link_idx_reg << cls_reg;
    assign link_off_nx = (link_idx_reg + 1'b1) << cls_reg;
    assign link_sum    = {1'b0, cur_avail} + (CNT_W+1)'(link_n);

    assign base      = addr_reg - ADDR_W'(HEADER_BYTES);
    assign free_page = base[PGOFF_W +: PAGE_W];
    assign free_slot = base[SLOT_SHIFT +: SLOT_W];
    assign free_mask = IDX_W'((IDX_W+1)'(1) << tag_rdata_reg) - 1'b1;
    assign free_bad  = (addr_reg < ADDR_W'(HEADER_BYTES))
                    || ({1'b0, free_page} >= next_page_reg)
                    || (tag_rdata_reg == NO_CLASS)
                    || (base[SLOT_SHIFT-1:0] != '0)
                    || ((base[SLOT_SHIFT +: IDX_W] & free_mask) != '0);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg[cls_reg];
        wr_en   = 1'b0;
        wr_addr = {link_page_reg, link_off};
        wr_data = link_last ? head_reg[cls_reg] : {link_page_reg, link_off_nx};
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en   = accept && (s_axis_tuser == KIND_ALLOC);
                rd_addr = head_reg[dec.cls];
            end
            S_LINK:
            begin
                wr_en = 1'b1;
            end
            S_POP_RD:
            begin
                rd_en = 1'b1;
            end
            S_FREE:
            begin
                wr_en   = out_free && !free_bad;
                wr_addr = free_slot;
                wr_data = head_reg[tag_rdata_reg];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            chunk_next[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            next_rdata_reg <= chunk_next[rd_addr];
        end
        if (state_reg == S_LINK && link_last)
        begin
            page_tag[link_page_reg] <= cls_reg;
        end
        if (accept)
        begin
            tag_rdata_reg <= page_tag[PAGE_W'((s_axis_tdata[38:21] - ADDR_W'(HEADER_BYTES))
                                              >> PGOFF_W)];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        load_data  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == KIND_FREE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (dec.status != ST_OK)
                    begin
                        state_next = S_RESP;
                    end
                    else if (avail_reg[dec.cls] != '0)
                    begin
                        state_next = S_POP;
                    end
                    else if (next_page_reg >= NUP_W'(POOL_PAGES))
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK:
            begin
                if (link_last)
                begin
                    if (!init_reg)
                    begin
                        state_next = S_POP_RD;
                    end
                    else if (cls_reg == CLS_W'(NUM_CLASSES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_data  = {2'b00, cur_avail - 1'b1, ST_OK, cls_reg,
                                  ADDR_W'({head_reg[cls_reg], {SLOT_SHIFT{1'b0}}})
                                  + ADDR_W'(HEADER_BYTES)};
                    state_next = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (free_bad)
                    begin
                        load_data = {2'b00, CNT_W'(0), ST_BAD_FREE, NO_CLASS, ADDR_W'(0)};
                    end
                    else
                    begin
                        load_data = {2'b00, (avail_reg[tag_rdata_reg] == AVAIL_MAX)
                                     ? AVAIL_MAX : avail_reg[tag_rdata_reg] + 1'b1,
                                     ST_OK, tag_rdata_reg, ADDR_W'(0)};
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_data  = {2'b00, CNT_W'(0), res_status_reg, cls_reg, ADDR_W'(0)};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LINK;
            init_reg       <= 1'b1;
            cls_reg        <= '0;
            res_status_reg <= ST_OK;
            addr_reg       <= '0;
            next_page_reg  <= '0;
            link_page_reg  <= '0;
            link_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                head_reg[k]  <= '0;
                avail_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                addr_reg       <= s_axis_tdata[38:21];
                cls_reg        <= dec.cls;
                link_page_reg  <= PAGE_W'(next_page_reg);
                link_idx_reg   <= '0;
                res_status_reg <= (dec.status == ST_OK) ? ST_NO_PAGES : dec.status;
            end

            unique case (state_reg)
                S_LINK:
                begin
                    link_idx_reg <= link_idx_reg + 1'b1;
                    if (link_last)
                    begin
                        head_reg[cls_reg]  <= {link_page_reg, IDX_W'(0)};
                        avail_reg[cls_reg] <= link_sum[CNT_W] ? AVAIL_MAX : link_sum[CNT_W-1:0];
                        next_page_reg      <= next_page_reg + 1'b1;
                        link_idx_reg       <= '0;
                        if (init_reg)
                        begin
                            if (cls_reg == CLS_W'(NUM_CLASSES - 1))
                            begin
                                init_reg <= 1'b0;
                            end
                            else
                            begin
                                cls_reg       <= cls_reg + 1'b1;
                                link_page_reg <= link_page_reg + 1'b1;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    if (out_free)
                    begin
                        head_reg[cls_reg]  <= next_rdata_reg;
                        avail_reg[cls_reg] <= cur_avail - 1'b1;
                    end
                end
                S_FREE:
                begin
                    if (out_free && !free_bad)
                    begin
                        head_reg[tag_rdata_reg]  <= free_slot;
                        avail_reg[tag_rdata_reg] <= (avail_reg[tag_rdata_reg] == AVAIL_MAX)
                                                    ? AVAIL_MAX
                                                    : avail_reg[tag_rdata_reg] + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= load_data;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("request accepted but the controller stayed idle");

    a_idle_after_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !init_reg)
        else $error("controller idle while the initial page linking is unfinished");

    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_page_reg <= NUP_W'(POOL_PAGES))
        else $error("page claim pointer beyond the pool");

    a_link_in_page: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> {1'b0, link_idx_reg} < link_n)
        else $error("link counter ran past the chunks of a page");
`endif

endmodule

// File: dv/size_class_chunk_allocator_test.sv
// ============================================================================
// Size-class chunk allocator testbench
// Drives allocate and free requests through the request stream with random
// gaps and output stalls, predicts every response with a behavioral model
// of the size classes, free lists and page tags, and compares field by field.
// ============================================================================
module size_class_chunk_allocator_test;
    import scca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  cls;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } grant_t;

    typedef struct {
        logic              kind;
        logic [REQ_W-1:0]  bytes;
        logic [ADDR_W-1:0] addr;
        logic              known;
        grant_t            resp;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    logic [CNT_W-1:0]  free_count [NUM_CLASSES];
    logic [ADDR_W-1:0] head_addr [NUM_CLASSES];
    logic [ADDR_W-1:0] link_addr [CHUNK_SLOTS];
    logic [CLS_W-1:0]  page_tag [POOL_PAGES];
    int                unused_page;

    grant_t      pending_grants[$];
    logic [ADDR_W-1:0] live_chunks[$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic        calm = 1'b0;

    size_class_chunk_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int chunk_bytes(int c);
        return 32 << c;
    endfunction

    function automatic void carve_page(int page, int c);
        int sz;
        int n;
        int base;
        sz = chunk_bytes(c);
        n = PAGE_BYTES / sz;
        base = page * PAGE_BYTES;
        for (int i = 0; i + 1 < n; i++)
        begin
            link_addr[(base + i * sz) / SLOT_BYTES] = ADDR_W'(base + (i + 1) * sz);
        end
        link_addr[(base + (n - 1) * sz) / SLOT_BYTES] = head_addr[c];
        head_addr[c] = ADDR_W'(base);
        page_tag[page] = CLS_W'(c);
        free_count[c] = (int'(free_count[c]) + n > int'(AVAIL_MAX)) ?
                        AVAIL_MAX : CNT_W'(int'(free_count[c]) + n);
    endfunction

    function automatic void reset_pool();
        for (int s = 0; s < CHUNK_SLOTS; s++)
        begin
            link_addr[s] = '0;
        end
        for (int p = 0; p < POOL_PAGES; p++)
        begin
            page_tag[p] = NO_CLASS;
        end
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head_addr[c] = '0;
            free_count[c] = '0;
            carve_page(c, c);
        end
        unused_page = NUM_CLASSES;
    endfunction

    function automatic grant_t predict_grant(logic kind, logic [REQ_W-1:0] bytes,
                                             logic [ADDR_W-1:0] addr);
        grant_t g;
        int need;
        int c;
        int base;
        int page;
        int page_off;
        int sz;
        int h;
        g = '{addr: '0, cls: NO_CLASS, status: ST_OK, count: '0};
        if (kind == KIND_ALLOC)
        begin
            need = int'(bytes) + HEADER_BYTES;
            if (bytes == 0)
            begin
                g.status = ST_ZERO_SIZE;
                return g;
            end
            for (c = 0; c < NUM_CLASSES; c++)
            begin
                if (need <= chunk_bytes(c))
                begin
                    break;
                end
            end
            if (c >= NUM_CLASSES)
            begin
                g.status = ST_TOO_LARGE;
                return g;
            end
            g.cls = CLS_W'(c);
            if (free_count[c] == 0)
            begin
                if (unused_page >= POOL_PAGES)
                begin
                    g.status = ST_NO_PAGES;
                    return g;
                end
                carve_page(unused_page, c);
                unused_page++;
            end
            h = int'(head_addr[c]);
            head_addr[c] = link_addr[(h / SLOT_BYTES) % CHUNK_SLOTS];
            free_count[c] = free_count[c] - 1'b1;
            g.addr = ADDR_W'(h + HEADER_BYTES);
            g.count = free_count[c];
            live_chunks.push_back(g.addr);
            return g;
        end
        g.status = ST_BAD_FREE;
        if (addr < HEADER_BYTES)
        begin
            return g;
        end
        base = int'(addr) - HEADER_BYTES;
        page = base / PAGE_BYTES;
        if (page >= POOL_PAGES || page_tag[page] == NO_CLASS)
        begin
            return g;
        end
        c = int'(page_tag[page]);
        sz = chunk_bytes(c);
        page_off = base % PAGE_BYTES;
        if (page_off % sz != 0 || page_off >= (PAGE_BYTES / sz) * sz)
        begin
            return g;
        end
        link_addr[(base / SLOT_BYTES) % CHUNK_SLOTS] = head_addr[c];
        head_addr[c] = ADDR_W'(base);
        free_count[c] = (free_count[c] == AVAIL_MAX) ? AVAIL_MAX : free_count[c] + 1'b1;
        g.cls = CLS_W'(c);
        g.status = ST_OK;
        g.count = free_count[c];
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_request(logic kind, logic [REQ_W-1:0] bytes,
                                logic [ADDR_W-1:0] addr, logic known, grant_t want);
        grant_t g;
        while (!calm && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        g = predict_grant(kind, bytes, addr);
        if (known && g !== want)
        begin
            report_mismatch("directed prediction", int'(g), int'(want));
        end
        pending_grants.push_back(g);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, addr, bytes};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{addr: m_axis_tdata[17:0], cls: m_axis_tdata[20:18],
                        status: m_axis_tdata[23:21], count: m_axis_tdata[37:24]};
                if (pending_grants.size() == 0)
                begin
                    report_mismatch("unexpected response", int'(got), 0);
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (got.addr !== want.addr)
                        report_mismatch("granted_address", got.addr, want.addr);
                    if (got.cls !== want.cls)
                        report_mismatch("size_class", got.cls, want.cls);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.count !== want.count)
                        report_mismatch("class_free_chunks", got.count, want.count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("size_class_chunk_allocator_test failed");
            $finish;
        end
    end

    row_t directed [] = '{
        '{KIND_ALLOC, 21'd0, 18'd0, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_ZERO_SIZE, count: 14'd0}},
        '{KIND_ALLOC, 21'h1FFFFF, 18'd0, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_TOO_LARGE, count: 14'd0}},
        '{KIND_ALLOC, 21'd2041, 18'd0, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_TOO_LARGE, count: 14'd0}},
        '{KIND_ALLOC, 21'd1, 18'h3FFFF, 1'b1,
          '{addr: 18'd8, cls: 3'd0, status: ST_OK, count: 14'd127}},
        '{KIND_ALLOC, 21'd24, 18'd0, 1'b1,
          '{addr: 18'd40, cls: 3'd0, status: ST_OK, count: 14'd126}},
        '{KIND_ALLOC, 21'd25, 18'd0, 1'b1,
          '{addr: 18'd4104, cls: 3'd1, status: ST_OK, count: 14'd63}},
        '{KIND_ALLOC, 21'd2040, 18'd0, 1'b1,
          '{addr: 18'd24584, cls: 3'd6, status: ST_OK, count: 14'd1}},
        '{KIND_ALLOC, 21'd1500, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd1016, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd504, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd248, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd120, 18'd0, 1'b0, '0},
        '{KIND_FREE, 21'h1FFFFF, 18'd0, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_BAD_FREE, count: 14'd0}},
        '{KIND_FREE, 21'd0, 18'd7, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_BAD_FREE, count: 14'd0}},
        '{KIND_FREE, 21'd0, 18'h3FFFF, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_BAD_FREE, count: 14'd0}},
        '{KIND_FREE, 21'd0, 18'd40000, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_BAD_FREE, count: 14'd0}},
        '{KIND_FREE, 21'd0, 18'd4112, 1'b1,
          '{addr: 18'd0, cls: NO_CLASS, status: ST_BAD_FREE, count: 14'd0}},
        '{KIND_FREE, 21'd0, 18'd24584, 1'b1,
          '{addr: 18'd0, cls: 3'd6, status: ST_OK, count: 14'd1}},
        '{KIND_FREE, 21'd0, 18'd24584, 1'b0, '0},
        '{KIND_ALLOC, 21'd2040, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd2040, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd2040, 18'd0, 1'b0, '0},
        '{KIND_ALLOC, 21'd2040, 18'd0, 1'b0, '0}
    };

    initial
    begin
        logic [REQ_W-1:0]  bytes;
        logic [ADDR_W-1:0] addr;
        int pick;
        reset_pool();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
        begin
            send_request(directed[i].kind, directed[i].bytes, directed[i].addr,
                         directed[i].known, directed[i].resp);
        end
        for (int n = 0; n < 650; n++)
        begin
            calm = (n >= 250 && n < 330);
            pick = $urandom_range(99);
            addr = ADDR_W'($urandom);
            if (pick < 45 || (pick < 55 && live_chunks.size() == 0))
            begin
                case ($urandom_range(9))
                    0: bytes = REQ_W'($urandom);
                    1: bytes = REQ_W'($urandom_range(2040, 1));
                    2: bytes = REQ_W'($urandom_range(1016, 500));
                    default: bytes = REQ_W'($urandom_range(250, 1));
                endcase
                send_request(KIND_ALLOC, bytes, addr, 1'b0, '0);
            end
            else if (pick < 90 && live_chunks.size() > 0)
            begin
                pick = $urandom_range(live_chunks.size() - 1);
                addr = live_chunks[pick];
                live_chunks.delete(pick);
                send_request(KIND_FREE, REQ_W'($urandom), addr, 1'b0, '0);
            end
            else
            begin
                if (pick < 95)
                begin
                    addr = ADDR_W'($urandom_range(unused_page * PAGE_BYTES + 8, 8));
                end
                send_request(KIND_FREE, REQ_W'($urandom), addr, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("size_class_chunk_allocator_test passed");
        end
        else
        begin
            $display("size_class_chunk_allocator_test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/scca_pkg.sv
design/scca_size_decode.sv
design/size_class_chunk_allocator.sv
dv/size_class_chunk_allocator_test.sv
